/* rtl/note_pitch_bend_vibrato_core_defines.svh */
// ============================================================================
// Assertion macros for the pitch bend and vibrato core
// Shared property forms; every use is clocked on clk and disabled in reset.
// ============================================================================
`ifndef NOTE_PITCH_BEND_VIBRATO_CORE_DEFINES_SVH
`define NOTE_PITCH_BEND_VIBRATO_CORE_DEFINES_SVH

// Same-cycle implication.
`define NPBV_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NPBV_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/npbv_pkg.sv */
// ============================================================================
// npbv_pkg
// Types, constants, divider step and sine table for the pitch bend core.
// ============================================================================
package npbv_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int K_W      = $clog2(SINE_TABLE_DEPTH);
  localparam int DEP_W    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PERIOD_W = 21;
  localparam int NUMK_W   = PERIOD_W + DEP_W;

  localparam int FRONT_STEPS = 32;
  localparam int SEG_STEPS   = 16;

  localparam logic [16:0] FULL_POS   = 17'd65536;
  localparam int          LIMIT_SEMI = 12288;
  localparam logic [11:0] MAX_DEPTH  = 12'd3072;
  localparam logic [20:0] MIN_PERIOD = 21'd655;
  localparam logic [20:0] MAX_PERIOD = 21'd1048576;

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] DEPTH64     = 64'(SINE_TABLE_DEPTH);

  // Fields of one item that travel down the pipeline.
  typedef struct packed {
    logic signed [14:0] tuning;
    logic signed [14:0] bend_from;
    logic signed [14:0] bend_top;
    logic signed [14:0] bend_to;
    logic [16:0]        point_first;
    logic [16:0]        point_middle;
    logic [16:0]        point_last;
    logic [11:0]        depth;
    logic [20:0]        period;
    logic [1:0]         mode;
    logic               bad;
    logic               sat;
  } side_t;

  // State of one restoring division lane: remainder, quotient, dividend bits.
  typedef struct packed {
    logic [31:0] r;
    logic [31:0] q;
    logic [31:0] n;
  } div_t;

  typedef logic signed [15:0] sine_tab_t [SINE_TABLE_DEPTH];

  // One restoring division step: bring in one dividend bit, trial subtract.
  function automatic div_t div_step(input div_t s, input logic [31:0] d);
    logic [32:0] t;
    logic        ge;
    div_t        o;
    t   = {s.r, s.n[31]};
    ge  = (t >= {1'b0, d});
    o.r = ge ? 32'(t - {1'b0, d}) : t[31:0];
    o.q = {s.q[30:0], ge};
    o.n = {s.n[30:0], 1'b0};
    return o;
  endfunction

  function automatic logic in_semi(input logic signed [14:0] v);
    return (v >= -LIMIT_SEMI) && (v <= LIMIT_SEMI);
  endfunction

  // Round to the nearest whole semitone, halves away from zero.
  function automatic logic signed [16:0] round_semi(input logic signed [16:0] v);
    logic [16:0] m;
    logic [16:0] s;
    logic [16:0] r;
    m = v[16] ? 17'(-v) : 17'(v);
    s = m + 17'd128;
    r = {s[16:8], 8'b0};
    return v[16] ? $signed(17'(-r)) : $signed(r);
  endfunction

  // Q1.14 sine table built at elaboration with Q2.30 Taylor arithmetic.
  function automatic sine_tab_t make_sine();
    sine_tab_t   tab;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [15:0] v;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q = 64'((4 * k) / SINE_TABLE_DEPTH);
      r = 64'((4 * k) % SINE_TABLE_DEPTH);
      if (q[0]) r = DEPTH64 - r;
      x  = (HALF_PI_Q30 * r) / DEPTH64;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = 16'((s + 64'd32768) >> 16);
      tab[k] = (q >= 64'd2) ? $signed(16'(-v)) : $signed(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = make_sine();

endpackage

/* rtl/npbv_front.sv */
// ============================================================================
// npbv_front
// Validity check plus two 32-step dividers: note position and elapsed mod period.
// ============================================================================
module npbv_front import npbv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        elapsed_time,
  input  logic [31:0]        note_length,
  input  logic signed [14:0] fine_tuning,
  input  logic signed [14:0] bend_from,
  input  logic signed [14:0] bend_top,
  input  logic signed [14:0] bend_to,
  input  logic [16:0]        point_first,
  input  logic [16:0]        point_middle,
  input  logic [16:0]        point_last,
  input  logic [11:0]        wobble_depth,
  input  logic [20:0]        wobble_period,
  input  logic [1:0]         shape_mode,
  output logic               out_valid,
  output side_t              out_side,
  output logic [15:0]        out_quot,
  output logic [PERIOD_W-1:0] out_rem
);

  side_t       side_in;
  side_t       sd    [FRONT_STEPS+1];
  div_t        pdiv  [FRONT_STEPS+1];
  div_t        mdiv  [FRONT_STEPS+1];
  logic [31:0] len_d [FRONT_STEPS+1];
  logic        vld   [FRONT_STEPS+1];

  // Gather the item and flag an invalid expression.
  always_comb begin
    side_in.tuning       = fine_tuning;
    side_in.bend_from    = bend_from;
    side_in.bend_top     = bend_top;
    side_in.bend_to      = bend_to;
    side_in.point_first  = point_first;
    side_in.point_middle = point_middle;
    side_in.point_last   = point_last;
    side_in.depth        = wobble_depth;
    side_in.period       = wobble_period;
    side_in.mode         = shape_mode;
    side_in.sat          = (note_length == 32'd0) || (elapsed_time >= note_length);
    side_in.bad = !(in_semi(fine_tuning) && in_semi(bend_from) && in_semi(bend_top) &&
                    in_semi(bend_to) && (point_first <= FULL_POS) &&
                    (point_middle >= point_first) && (point_middle <= FULL_POS) &&
                    (point_last >= point_middle) && (point_last <= FULL_POS) &&
                    (wobble_depth <= MAX_DEPTH) && (wobble_period >= MIN_PERIOD) &&
                    (wobble_period <= MAX_PERIOD));
  end

  // Load the dividers, then one quotient bit per stage in each lane.
  always_ff @(posedge clk) begin
    pdiv[0]  <= '{r: {16'b0, elapsed_time[31:16]}, q: '0, n: {elapsed_time[15:0], 16'b0}};
    mdiv[0]  <= '{r: '0, q: '0, n: elapsed_time};
    len_d[0] <= note_length;
    sd[0]    <= side_in;
    for (int i = 1; i <= FRONT_STEPS; i++) begin
      pdiv[i]  <= div_step(pdiv[i-1], len_d[i-1]);
      mdiv[i]  <= div_step(mdiv[i-1], {11'b0, sd[i-1].period});
      len_d[i] <= len_d[i-1];
      sd[i]    <= sd[i-1];
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= FRONT_STEPS; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i <= FRONT_STEPS; i++) vld[i] <= vld[i-1];
    end
  end

  assign out_valid = vld[FRONT_STEPS];
  assign out_side  = sd[FRONT_STEPS];
  assign out_quot  = pdiv[FRONT_STEPS].q[15:0];
  assign out_rem   = mdiv[FRONT_STEPS].r[PERIOD_W-1:0];

endmodule

/* rtl/npbv_bend.sv */
// ============================================================================
// npbv_bend
// Segment select, 16-step fraction divider, shaping, interpolation, rounding.
// ============================================================================
module npbv_bend import npbv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  side_t              in_side,
  input  logic [15:0]        in_quot,
  output logic               out_valid,
  output logic signed [15:0] out_bend,
  output logic signed [14:0] out_tuning,
  output logic               out_bad
);

  typedef struct packed {
    logic signed [14:0] a;
    logic signed [14:0] b;
    logic               sel_a;
    logic               sel_b;
    logic [16:0]        den;
    logic               quad;
    logic               rnd;
    logic signed [14:0] tuning;
    logic               bad;
  } bctl_t;

  localparam int LAST = SEG_STEPS + 3;

  logic [16:0]        pos;
  logic [16:0]        first;
  logic [16:0]        last;
  bctl_t              ctl_in;
  bctl_t              ctl  [SEG_STEPS+3];
  div_t               sdiv [SEG_STEPS+1];
  logic [15:0]        f2;
  logic signed [15:0] diff;
  logic signed [32:0] prod;
  logic signed [16:0] lerp;
  logic signed [16:0] pick;
  logic signed [15:0] bend;
  logic signed [14:0] tun_r;
  logic               bad_r;
  logic               vld  [LAST+1];

  // Choose the segment and its degenerate cases.
  always_comb begin
    pos = in_side.sat ? FULL_POS : {1'b0, in_quot};
    if (pos < in_side.point_middle) begin
      ctl_in.a = in_side.bend_from;
      ctl_in.b = in_side.bend_top;
      first    = in_side.point_first;
      last     = in_side.point_middle;
    end else begin
      ctl_in.a = in_side.bend_top;
      ctl_in.b = in_side.bend_to;
      first    = in_side.point_middle;
      last     = in_side.point_last;
    end
    ctl_in.sel_a  = (pos <= first);
    ctl_in.sel_b  = (pos >= last) || (first == last);
    ctl_in.den    = last - first;
    ctl_in.quad   = in_side.mode[0];
    ctl_in.rnd    = in_side.mode[1];
    ctl_in.tuning = in_side.tuning;
    ctl_in.bad    = in_side.bad;
  end

  // Interpolation, endpoint override and rounding of the final value.
  always_comb begin
    lerp = ctl[SEG_STEPS+2].a + 17'(prod >>> 16);
    if (ctl[SEG_STEPS+2].sel_a)      pick = 17'(ctl[SEG_STEPS+2].a);
    else if (ctl[SEG_STEPS+2].sel_b) pick = 17'(ctl[SEG_STEPS+2].b);
    else                             pick = lerp;
    if (ctl[SEG_STEPS+2].rnd) pick = round_semi(pick);
  end

  always_ff @(posedge clk) begin
    ctl[0]  <= ctl_in;
    sdiv[0] <= '{r: {15'b0, 17'(pos - first)}, q: '0, n: '0};
    for (int i = 1; i <= SEG_STEPS; i++) begin
      sdiv[i] <= div_step(sdiv[i-1], {15'b0, ctl[i-1].den});
      ctl[i]  <= ctl[i-1];
    end
    // Quadratic shaping of the fraction.
    f2   <= ctl[SEG_STEPS].quad ?
            16'((32'(sdiv[SEG_STEPS].q[15:0]) * 32'(sdiv[SEG_STEPS].q[15:0])) >> 16) :
            sdiv[SEG_STEPS].q[15:0];
    diff <= 16'(ctl[SEG_STEPS].b) - 16'(ctl[SEG_STEPS].a);
    ctl[SEG_STEPS+1] <= ctl[SEG_STEPS];
    // Scale the span by the fraction.
    prod <= diff * $signed({1'b0, f2});
    ctl[SEG_STEPS+2] <= ctl[SEG_STEPS+1];
    // Interpolate, override and round.
    bend  <= 16'(pick);
    tun_r <= ctl[SEG_STEPS+2].tuning;
    bad_r <= ctl[SEG_STEPS+2].bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i <= LAST; i++) vld[i] <= vld[i-1];
    end
  end

  assign out_valid  = vld[LAST];
  assign out_bend   = bend;
  assign out_tuning = tun_r;
  assign out_bad    = bad_r;

endmodule

/* rtl/npbv_wobble.sv */
// ============================================================================
// npbv_wobble
// Vibrato: table index divider, sine lookup, depth scaling and rounding.
// ============================================================================
module npbv_wobble import npbv_pkg::*; (
  input  logic                clk,
  input  logic [PERIOD_W-1:0] in_rem,
  input  logic [11:0]         in_depth,
  input  logic [20:0]         in_period,
  output logic signed [15:0]  out_vib
);

  logic [NUMK_W-1:0]  numk;
  div_t               kdiv   [SEG_STEPS+1];
  logic [20:0]        per_d  [SEG_STEPS+1];
  logic [11:0]        dep_d  [SEG_STEPS+2];
  logic signed [15:0] sine;
  logic signed [28:0] prod;
  logic signed [28:0] prod_r;
  logic signed [15:0] vib;

  // Scale the phase remainder by the table depth.
  assign numk = NUMK_W'(in_rem) * NUMK_W'(SINE_TABLE_DEPTH);
  assign prod = $signed({1'b0, dep_d[SEG_STEPS+1]}) * sine;

  always_ff @(posedge clk) begin
    kdiv[0]  <= '{r: 32'(numk >> 16), q: '0, n: {numk[15:0], 16'b0}};
    per_d[0] <= in_period;
    dep_d[0] <= in_depth;
    for (int i = 1; i <= SEG_STEPS; i++) begin
      kdiv[i]  <= div_step(kdiv[i-1], {11'b0, per_d[i-1]});
      per_d[i] <= per_d[i-1];
      dep_d[i] <= dep_d[i-1];
    end
    // Registered table read.
    sine <= SINE_TAB[kdiv[SEG_STEPS].q[K_W-1:0]];
    dep_d[SEG_STEPS+1] <= dep_d[SEG_STEPS];
    // Depth times sine, then round back to Q7.8.
    prod_r <= prod;
    vib    <= 16'((prod_r + 29'sd8192) >>> 14);
  end

  assign out_vib = vib;

endmodule

/* rtl/note_pitch_bend_vibrato_core.sv */
// ============================================================================
// note_pitch_bend_vibrato_core
// Pitch offset of one note from its bend shape, tuning and sine vibrato.
// ============================================================================
//   channel   signals                                   direction
//   command   start, busy, item fields                  in (busy out)
//   result    done, pitch_offset, bad_expression        out
//
// One item enters per cycle; busy is always low. A result passes through 33
// stages for the position and phase dividers, 20 for the fraction and
// table-index dividers with shaping, and one summing stage.
// The one-bit-per-stage restoring dividers set the depth of the pipeline.
// Reset (synchronous) clears the valid bits only; items in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
`include "note_pitch_bend_vibrato_core_defines.svh"

module note_pitch_bend_vibrato_core import npbv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        elapsed_time,
  input  logic [31:0]        note_length,
  input  logic signed [14:0] fine_tuning,
  input  logic signed [14:0] bend_from,
  input  logic signed [14:0] bend_top,
  input  logic signed [14:0] bend_to,
  input  logic [16:0]        point_first,
  input  logic [16:0]        point_middle,
  input  logic [16:0]        point_last,
  input  logic [11:0]        wobble_depth,
  input  logic [20:0]        wobble_period,
  input  logic [1:0]         shape_mode,
  output logic               done,
  output logic signed [15:0] pitch_offset,
  output logic               bad_expression
);

  logic                f_valid;
  side_t               f_side;
  logic [15:0]         f_quot;
  logic [PERIOD_W-1:0] f_rem;
  logic                b_valid;
  logic signed [15:0]  b_bend;
  logic signed [14:0]  b_tuning;
  logic                b_bad;
  logic signed [15:0]  w_vib;
  logic signed [17:0]  total;
  logic signed [15:0]  clamped;

  assign busy = 1'b0;

  npbv_front u_front (
    .clk, .rst, .in_valid(start && !busy),
    .elapsed_time, .note_length, .fine_tuning, .bend_from, .bend_top, .bend_to,
    .point_first, .point_middle, .point_last, .wobble_depth, .wobble_period,
    .shape_mode,
    .out_valid(f_valid), .out_side(f_side), .out_quot(f_quot), .out_rem(f_rem)
  );

  npbv_bend u_bend (
    .clk, .rst, .in_valid(f_valid), .in_side(f_side), .in_quot(f_quot),
    .out_valid(b_valid), .out_bend(b_bend), .out_tuning(b_tuning), .out_bad(b_bad)
  );

  npbv_wobble u_wobble (
    .clk, .in_rem(f_rem), .in_depth(f_side.depth), .in_period(f_side.period),
    .out_vib(w_vib)
  );

  // Sum the three parts and saturate to 16 bits.
  always_comb begin
    total = 18'(b_tuning) + 18'(b_bend) + 18'(w_vib);
    if (total > 18'sd32767)       clamped = 16'sh7FFF;
    else if (total < -18'sd32768) clamped = 16'sh8000;
    else                          clamped = 16'(total);
  end

  always_ff @(posedge clk) begin
    pitch_offset   <= b_bad ? 16'sd0 : clamped;
    bad_expression <= b_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_valid;
    end
  end

  `NPBV_CHECK(a_bad_zero, done && bad_expression, pitch_offset == 16'sd0, "bad item nonzero")
  `NPBV_CHECK(a_out_range, done && !bad_expression, (pitch_offset >= -16'sd27648) && (pitch_offset <= 16'sd27648), "pitch out of range")
  `NPBV_CHECK(a_bend_range, b_valid && !b_bad, (b_bend >= -16'sd12288) && (b_bend <= 16'sd12288), "bend out of range")
  `NPBV_CHECK(a_vib_range, b_valid && !b_bad, (w_vib >= -16'sd3072) && (w_vib <= 16'sd3072), "vibrato out of range")
  `NPBV_CHECK_NEXT(a_done_follows, b_valid, done && (bad_expression == $past(b_bad)), "result lost")

endmodule
